// ===== src/wrp_pkg.sv =====
// Package for the water ripple propagation block.
// Holds defaults, size limits and the configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package wrp_pkg;

   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_HEIGHT      = 1024;
   localparam int MIN_SIZE        = 3;
   localparam int NEIGH_SHIFT     = 2;

   localparam int ROW_BITS   = 10;   // cell_row / cell_col field width
   localparam int SIZE_BITS  = 11;   // grid_width / grid_height registers
   localparam int DAMP_BITS  = 4;
   localparam int CSR_BITS   = 11;   // widest register
   localparam int CSR_IDX_BITS = 2;

   localparam logic [SIZE_BITS-1:0] GRID_WIDTH_RST  = 11'd640;
   localparam logic [SIZE_BITS-1:0] GRID_HEIGHT_RST = 11'd480;
   localparam logic [DAMP_BITS-1:0] DAMPING_RST     = 4'd4;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1,
      CSR_DAMPING     = 2'd2
   } csr_index_type;

endpackage

// ===== src/wrp_line_ram.sv =====
// Line buffer RAM: one write port, one read port, registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module wrp_line_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/water_ripple_propagation.sv =====
// Water ripple propagation: one grid step, streamed in raster order.
//
// Usage:
//   req_* carries one grid cell per request: the current sample and the
//   older grid's sample at the same place, rows left to right, top down.
//   rsp_* returns the new energy of each interior cell with its row and
//   column; rsp_tlast marks the last interior cell of the grid. Border
//   cells produce no response.
//   csr_* writes grid_width (0), grid_height (1), damping_shift (2); write
//   only while no request is in flight.
// Throughput: one request per cycle while the receiver keeps up. Each request
//   does one read and one write of the shared line RAM (both line buffers plus
//   the older line in one word), so the single RAM port pair sets the rate.
// Pipeline: the response for cell (r-1, c-1) is produced from cell (r, c)
//   through RAM read, stencil sum, subtract and decay, each registered.
// Reset clears the position counters, window and pipeline valids and loads
//   the register defaults (640 x 480, damping 4). Line RAM is not cleared.
// Receiver stall: the result waits in the output register; requests keep
//   being taken while the pipeline has an empty stage, then req_tready drops.
// Depends on wrp_pkg and wrp_line_ram.
`timescale 1ns / 1ps

module water_ripple_propagation #(
   parameter int MAX_WIDTH   = wrp_pkg::MAX_WIDTH_DEF,
   parameter int SAMPLE_BITS = wrp_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: [SB-1:0] active_sample, [2SB-1:SB] older_sample
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [2*SAMPLE_BITS-1:0]            req_tdata,
   // response: new_energy, cell_row, cell_col from bit 0 up, zero padded
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((SAMPLE_BITS+2*wrp_pkg::ROW_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic [wrp_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [wrp_pkg::CSR_BITS-1:0]        csr_wdata
);

   localparam int SB   = SAMPLE_BITS;
   localparam int SW   = SB + 3;                 // sum of eight samples
   localparam int CB   = $clog2(MAX_WIDTH);      // column counter
   localparam int WB   = $clog2(MAX_WIDTH + 1);  // holds MAX_WIDTH
   localparam int RB   = wrp_pkg::ROW_BITS;
   localparam int HB   = wrp_pkg::SIZE_BITS;
   localparam int RSPW = ((SB + 2 * RB + 7) / 8) * 8;
   localparam int PADW = RSPW - SB - 2 * RB;

   // ---------------- configuration
   logic [HB-1:0]                  grid_width_ff;
   logic [HB-1:0]                  grid_height_ff;
   logic [wrp_pkg::DAMP_BITS-1:0]  damping_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= wrp_pkg::GRID_WIDTH_RST;
         grid_height_ff <= wrp_pkg::GRID_HEIGHT_RST;
         damping_ff     <= wrp_pkg::DAMPING_RST;
      end else if (csr_wr_en) begin
         case (wrp_pkg::csr_index_type'(csr_index))
            wrp_pkg::CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata[HB-1:0];
            wrp_pkg::CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata[HB-1:0];
            wrp_pkg::CSR_DAMPING:     damping_ff     <= csr_wdata[wrp_pkg::DAMP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamp sizes to the supported range
   logic [WB-1:0] eff_w;
   logic [HB-1:0] eff_h;
   logic [31:0]   gw32;
   logic [31:0]   gh32;

   always_comb begin
      gw32 = 32'(grid_width_ff);
      gh32 = 32'(grid_height_ff);
      if (gw32 < 32'(wrp_pkg::MIN_SIZE))
         eff_w = WB'(wrp_pkg::MIN_SIZE);
      else if (gw32 > 32'(MAX_WIDTH))
         eff_w = WB'(MAX_WIDTH);
      else
         eff_w = WB'(gw32);
      if (gh32 < 32'(wrp_pkg::MIN_SIZE))
         eff_h = HB'(wrp_pkg::MIN_SIZE);
      else if (gh32 > 32'(wrp_pkg::MAX_HEIGHT))
         eff_h = HB'(wrp_pkg::MAX_HEIGHT);
      else
         eff_h = gh32[HB-1:0];
   end

   // ---------------- handshake / stage enables
   logic p1_v_ff, p2_v_ff, p3_v_ff, out_v_ff;
   logic out_ready, en2, en1, accept, adv1;

   assign out_ready  = !out_v_ff || rsp_tready;
   assign en2        = !p3_v_ff || out_ready;
   assign en1        = !p2_v_ff || en2;
   assign req_tready = !p1_v_ff || en1;
   assign accept     = req_tvalid && req_tready;
   assign adv1       = p1_v_ff && en1;

   // ---------------- position counters (position of the next request)
   logic [CB-1:0] col_count_ff, col_count_in;
   logic [RB-1:0] row_count_ff, row_count_in;
   logic          emit, last;

   always_comb begin
      emit = (row_count_ff >= RB'(2)) && (col_count_ff >= CB'(2)) &&
             (HB'(row_count_ff) < eff_h) && (WB'(col_count_ff) < eff_w);
      last = (HB'(row_count_ff) == eff_h - HB'(1)) &&
             (WB'(col_count_ff) == eff_w - WB'(1));
      col_count_in = col_count_ff + CB'(1);
      row_count_in = row_count_ff;
      if (WB'(col_count_ff) + WB'(1) >= eff_w) begin
         col_count_in = '0;
         if (HB'(row_count_ff) + HB'(1) >= eff_h)
            row_count_in = '0;
         else
            row_count_in = row_count_ff + RB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // ---------------- stage 1: RAM read in flight
   logic [SB-1:0] p1_act_ff, p1_old_ff;
   logic [CB-1:0] p1_col_ff;
   logic [RB-1:0] p1_orow_ff, p1_ocol_ff;
   logic          p1_emit_ff, p1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (req_tready) begin
         p1_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_act_ff  <= req_tdata[SB-1:0];
         p1_old_ff  <= req_tdata[2*SB-1:SB];
         p1_col_ff  <= col_count_ff;
         p1_orow_ff <= row_count_ff - RB'(1);
         p1_ocol_ff <= RB'(col_count_ff - CB'(1));
         p1_emit_ff <= emit;
         p1_last_ff <= last;
      end
   end

   // line RAM word: {older, middle, upper}
   logic [3*SB-1:0] rd_word, wr_word;
   logic [SB-1:0]   rd_upper, rd_middle, rd_older;

   assign rd_upper  = rd_word[SB-1:0];
   assign rd_middle = rd_word[2*SB-1:SB];
   assign rd_older  = rd_word[3*SB-1:2*SB];
   // middle row moves up, new sample becomes middle
   assign wr_word   = {p1_old_ff, p1_act_ff, rd_middle};

   wrp_line_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (3 * SB)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_count_ff),
      .rd_data (rd_word),
      .wr_en   (adv1),
      .wr_addr (p1_col_ff),
      .wr_data (wr_word)
   );

   // ---------------- window: columns 1 and 2 of each row, plus older hold
   logic [SB-1:0] win1_ff [0:2];
   logic [SB-1:0] win2_ff [0:2];
   logic [SB-1:0] older_hold_ff;
   logic signed [SW-1:0] sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            win1_ff[i] <= '0;
            win2_ff[i] <= '0;
         end
         older_hold_ff <= '0;
      end else if (adv1) begin
         for (int i = 0; i < 3; i++) begin
            win1_ff[i] <= win2_ff[i];
         end
         win2_ff[0]    <= rd_upper;
         win2_ff[1]    <= rd_middle;
         win2_ff[2]    <= p1_act_ff;
         older_hold_ff <= rd_older;
      end
   end

   // eight neighbours of the window after the shift; center is win2_ff[1]
   assign sum = SW'($signed(win1_ff[0])) + SW'($signed(win2_ff[0])) +
                SW'($signed(rd_upper))   + SW'($signed(win1_ff[1])) +
                SW'($signed(rd_middle))  + SW'($signed(win1_ff[2])) +
                SW'($signed(win2_ff[2])) + SW'($signed(p1_act_ff));

   // ---------------- stage 2: neighbour sum
   logic signed [SW-1:0] p2_sum_ff;
   logic signed [SB-1:0] p2_cold_ff;
   logic [RB-1:0]        p2_row_ff, p2_col_ff;
   logic                 p2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_v_ff <= 1'b0;
      end else if (en1) begin
         p2_v_ff <= adv1 && p1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         p2_sum_ff  <= sum;
         p2_cold_ff <= $signed(older_hold_ff);
         p2_row_ff  <= p1_orow_ff;
         p2_col_ff  <= p1_ocol_ff;
         p2_last_ff <= p1_last_ff;
      end
   end

   // ---------------- stage 3: (sum asr 2) - older, wrapped
   logic signed [SW-1:0] diff;
   logic signed [SB-1:0] p3_val_ff;
   logic [RB-1:0]        p3_row_ff, p3_col_ff;
   logic                 p3_last_ff;

   assign diff = (p2_sum_ff >>> wrp_pkg::NEIGH_SHIFT) - SW'(p2_cold_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_v_ff <= 1'b0;
      end else if (en2) begin
         p3_v_ff <= p2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && p2_v_ff) begin
         p3_val_ff  <= $signed(diff[SB-1:0]);
         p3_row_ff  <= p2_row_ff;
         p3_col_ff  <= p2_col_ff;
         p3_last_ff <= p2_last_ff;
      end
   end

   // ---------------- output register: decay
   logic signed [SB-1:0] decayed;
   logic [SB-1:0]        out_val_ff;
   logic [RB-1:0]        out_row_ff, out_col_ff;
   logic                 out_last_ff;

   assign decayed = p3_val_ff - (p3_val_ff >>> damping_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_ready) begin
         out_v_ff <= p3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && p3_v_ff) begin
         out_val_ff  <= decayed;
         out_row_ff  <= p3_row_ff;
         out_col_ff  <= p3_col_ff;
         out_last_ff <= p3_last_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {PADW'(0), out_col_ff, out_row_ff, out_val_ff};
   assign rsp_tlast  = out_last_ff;

   // ---------------- assertions
   // the RAM never reads the entry whose write-back is pending
   a_no_raw_same_entry: assert property (@(posedge clock) disable iff (reset)
      (accept && p1_v_ff) |-> (col_count_ff != p1_col_ff))
      else $error("line RAM read hits pending write");

   // no emitted cell lies in row 0 or column 0
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (out_row_ff != '0) && (out_col_ff != '0))
      else $error("border cell emitted");

   // frame end is flagged on the last interior column
   a_last_column: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_last_ff) |-> (out_col_ff == RB'(eff_w - WB'(2))))
      else $error("tlast on wrong column");

   // an empty stage 1 never creates a response
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (en1 && !p1_v_ff) |=> !p2_v_ff)
      else $error("response from empty stage");

endmodule

// ===== test/tb_water_ripple_propagation.sv =====
// Self-checking testbench for water_ripple_propagation: directed and random grid
// frames with random stalls on both streams, checked against a cycle-free predictor.
// Depends on wrp_pkg and the block under test.
`timescale 1ns / 1ps

module tb_water_ripple_propagation;

   localparam int SB           = wrp_pkg::SAMPLE_BITS_DEF;
   localparam int ROW_W        = wrp_pkg::ROW_BITS;
   localparam int SIZE_W       = wrp_pkg::SIZE_BITS;
   localparam int DAMP_W       = wrp_pkg::DAMP_BITS;
   localparam int CSR_W        = wrp_pkg::CSR_BITS;
   localparam int IDX_W        = wrp_pkg::CSR_IDX_BITS;
   localparam int MAX_W        = wrp_pkg::MAX_WIDTH_DEF;
   localparam int RSP_BITS     = ((SB + 2 * ROW_W + 7) / 8) * 8;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_CELLS = 700;
   localparam int PRIME_WIDTH  = 128;   // widest grid used after priming
   localparam logic [SB-1:0] EDGE_VALUES [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                                16'h0001};

   typedef struct {
      logic signed [SB-1:0]  energy;
      logic [ROW_W-1:0]      row;
      logic [ROW_W-1:0]      col;
      logic                  last;
   } cell_result_type;

   class ripple_scoreboard;
      logic [SIZE_W-1:0]     width_reg;
      logic [SIZE_W-1:0]     height_reg;
      logic [DAMP_W-1:0]     damping_reg;
      logic signed [SB-1:0]  upper_row [MAX_W];
      logic signed [SB-1:0]  middle_row [MAX_W];
      logic signed [SB-1:0]  older_row [MAX_W];
      logic signed [SB-1:0]  older_hold;
      logic signed [SB-1:0]  window [3][3];
      int unsigned           row_pos;
      int unsigned           col_pos;
      cell_result_type       due_cells [$];
      int                    errors;

      function new();
         width_reg   = wrp_pkg::GRID_WIDTH_RST;
         height_reg  = wrp_pkg::GRID_HEIGHT_RST;
         damping_reg = wrp_pkg::DAMPING_RST;
         foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
            older_row[i]  = '0;
         end
         foreach (window[i, j]) window[i][j] = '0;
         older_hold = '0;
         row_pos    = 0;
         col_pos    = 0;
         errors     = 0;
      endfunction

      function int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned hi);
         if (v < wrp_pkg::MIN_SIZE) return wrp_pkg::MIN_SIZE;
         if (v > hi) return hi;
         return 32'(v);
      endfunction

      function void write_register(wrp_pkg::csr_index_type idx, logic [CSR_W-1:0] value);
         case (idx)
            wrp_pkg::CSR_GRID_WIDTH:  width_reg   = value[SIZE_W-1:0];
            wrp_pkg::CSR_GRID_HEIGHT: height_reg  = value[SIZE_W-1:0];
            wrp_pkg::CSR_DAMPING:     damping_reg = value[DAMP_W-1:0];
            default: ;
         endcase
      endfunction

      // cells still to send until the position counters are back at (0, 0)
      function int unsigned frame_remaining();
         int unsigned w;
         int unsigned h;
         int unsigned n;
         w = clamp_size(width_reg, MAX_W);
         h = clamp_size(height_reg, wrp_pkg::MAX_HEIGHT);
         n = (col_pos >= w) ? 1 : w - col_pos;
         if (row_pos + 1 < h) n += (h - row_pos - 1) * w;
         return n;
      endfunction

      function void note_request(logic signed [SB-1:0] act, logic signed [SB-1:0] old);
         int unsigned          w;
         int unsigned          h;
         int unsigned          c;
         int unsigned          r;
         int unsigned          ci;
         int                   sum;
         int                   v;
         logic signed [SB-1:0] center_old;
         logic signed [SB-1:0] raw;
         cell_result_type      entry;
         w  = clamp_size(width_reg, MAX_W);
         h  = clamp_size(height_reg, wrp_pkg::MAX_HEIGHT);
         c  = col_pos;
         r  = row_pos;
         ci = (c < MAX_W) ? c : MAX_W - 1;
         center_old = older_hold;
         for (int i = 0; i < 3; i++) begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
         end
         window[0][2]  = upper_row[ci];
         window[1][2]  = middle_row[ci];
         window[2][2]  = act;
         upper_row[ci] = middle_row[ci];
         middle_row[ci] = act;
         older_hold    = older_row[ci];
         older_row[ci] = old;

         if (r >= 2 && c >= 2 && r < h && c < w) begin
            sum = 0;
            foreach (window[i, j]) begin
               if (i != 1 || j != 1) sum += 32'(window[i][j]);
            end
            // wrap before decay, as a cast to 16 bits would
            raw = SB'((sum >>> wrp_pkg::NEIGH_SHIFT) - center_old);
            v   = 32'(raw) - (32'(raw) >>> damping_reg);
            entry.energy = SB'(v);
            entry.row    = ROW_W'(r - 1);
            entry.col    = ROW_W'(c - 1);
            entry.last   = (r == h - 1 && c == w - 1);
            due_cells.push_back(entry);
         end

         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
         end
      endfunction

      function void compare_field(string name, logic signed [31:0] expv,
                                  logic signed [31:0] actv);
         if (actv !== expv) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, expv, actv);
            errors++;
         end
      endfunction

      function void check_response(logic [RSP_BITS-1:0] data, logic last);
         cell_result_type entry;
         if (due_cells.size() == 0) begin
            $display("%0t: response with none expected: tdata %h tlast %b", $time, data, last);
            errors++;
            return;
         end
         entry = due_cells.pop_front();
         compare_field("new_energy", 32'(entry.energy), 32'($signed(data[SB-1:0])));
         compare_field("cell_row", 32'(entry.row), 32'(data[SB +: ROW_W]));
         compare_field("cell_col", 32'(entry.col), 32'(data[SB + ROW_W +: ROW_W]));
         compare_field("frame_last", 32'(entry.last), 32'(last));
      endfunction

      function int pending();
         return due_cells.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [2*SB-1:0]         req_tdata = '0;     // active_sample, older_sample
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]     rsp_tdata;          // new_energy, cell_row, cell_col, pad
   logic                    rsp_tlast;
   logic                    csr_wr_en = 1'b0;
   logic [IDX_W-1:0]        csr_index = '0;
   logic [CSR_W-1:0]        csr_wdata = '0;

   ripple_scoreboard sb;
   int   idle_cycles = 0;
   int   stall_left = 0;
   int   cells_sent = 0;
   logic req_idle_on = 1'b1;
   logic rsp_idle_on = 1'b1;

   water_ripple_propagation u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [SB-1:0] pick_sample();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return SB'($urandom);
      if (roll < 55) return EDGE_VALUES[$urandom_range(0, 4)];
      return SB'($urandom_range(0, 2000) - 1000);
   endfunction

   // monitor and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata[SB-1:0], req_tdata[2*SB-1:SB]);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("water_ripple_propagation regression: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // response side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!rsp_idle_on || $urandom_range(0, 3) != 0) begin
         rsp_tready <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_tready <= 1'b0;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_cell(input logic [SB-1:0] act, input logic [SB-1:0] old);
      int gap;
      gap = req_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {old, act};
      do begin
         @(posedge clock);
      end while (!req_tready);
      @(negedge clock);
      cells_sent++;
   endtask

   task automatic send_cells(input int unsigned count);
      repeat (count) send_cell(pick_sample(), pick_sample());
   endtask

   task automatic directed_frame(input logic [SB-1:0] act_a, input logic [SB-1:0] act_b,
                                 input logic [SB-1:0] old_v);
      int unsigned n;
      n = sb.frame_remaining();
      for (int unsigned i = 0; i < n; i++) send_cell((i % 2) ? act_b : act_a, old_v);
   endtask

   // drain all responses, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_csr(input wrp_pkg::csr_index_type idx, input logic [CSR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_register(idx, value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic [DAMP_W-1:0] d);
      logic [CSR_W-1:0] damp_word;
      damp_word = CSR_W'($urandom);   // upper bits are don't-care
      damp_word[DAMP_W-1:0] = d;
      write_csr(wrp_pkg::CSR_GRID_WIDTH, w);
      write_csr(wrp_pkg::CSR_GRID_HEIGHT, h);
      write_csr(wrp_pkg::CSR_DAMPING, damp_word);
   endtask

   initial begin
      int                base;
      int                roll;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sizes below minimum, zero damping, alternating extremes
      configure(11'd0, 11'd1, 4'd0);
      directed_frame(16'h7FFF, 16'h8000, 16'h0001);
      settle();
      // neighbour sum overflows the 16-bit wrap, slowest decay
      configure(11'd3, 11'd3, 4'd15);
      directed_frame(16'h7FFF, 16'h7FFF, 16'h8000);
      settle();
      // faster decay, negative wrap
      configure(11'd3, 11'd3, 4'd2);
      directed_frame(16'h8000, 16'h8000, 16'h7FFF);
      settle();

      // widest grid of the run first: every line buffer column used later
      // gets written before any mid-frame resize can touch it
      configure(SIZE_W'(PRIME_WIDTH), 11'd3, DAMP_W'($urandom_range(0, 15)));
      send_cells(sb.frame_remaining());
      settle();
      // height above the limit clamps; only the top of this frame is sent
      configure(11'd3, 11'h7FF, DAMP_W'($urandom_range(0, 15)));
      send_cells(900);

      base = cells_sent;
      while (cells_sent < base + RANDOM_CELLS) begin
         settle();
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            w = SIZE_W'($urandom_range(0, 2));
            h = SIZE_W'($urandom_range(0, 12));
         end else if (roll < 15) begin
            w = SIZE_W'($urandom_range(17, PRIME_WIDTH));
            h = SIZE_W'($urandom_range(0, 4));
         end else begin
            w = SIZE_W'($urandom_range(3, 16));
            h = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(0, 2))
                                            : SIZE_W'($urandom_range(3, 12));
         end
         configure(w, h, DAMP_W'($urandom_range(0, 15)));
         // mostly whole frames; sometimes stop mid-frame so the next
         // configuration lands in the middle of a grid
         if ($urandom_range(0, 4) == 0) begin
            send_cells($urandom_range(1, sb.frame_remaining()));
         end else begin
            repeat ($urandom_range(1, 2)) send_cells(sb.frame_remaining());
         end
      end
      settle();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("water_ripple_propagation regression: pass");
      end else begin
         $display("water_ripple_propagation regression: fail");
      end
      $finish;
   end

endmodule
